@@ hw/rtl/elqa_pkg.sv @@
// shared constants, types and term tables for the edge line quadric accumulator
// depends on nothing; imported by edge_line_quadric_accumulator_top and the testbench
`default_nettype none

package elqa_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int COORD_FRAC_BITS = 16;
    localparam int ACC_FRAC_BITS   = 32;
    localparam int UNIT_FRAC       = 30;
    localparam int NUM_TERMS       = 10;

    // scaled vectors keep their largest magnitude in [2^(SCALE_HI-1), 2^SCALE_HI)
    localparam int SCALE_HI     = 24;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int CROSS_W      = 2 * DIFF_W;
    localparam int SQ_W         = 2 * SCALE_HI;
    localparam int SUM_W        = SQ_W + 2;
    localparam int AXIS_W       = SUM_W + 8;
    localparam int UNIT_W       = UNIT_FRAC + 2;
    localparam int DOT_W        = UNIT_W + COORD_WIDTH + 2;
    localparam int ACC_W        = 64;
    localparam int HALF_W       = 32;
    localparam int PROD_W       = 2 * ACC_W;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = ROOT_W + 1;
    localparam int SQRT_PRE     = 12;
    localparam int DIV_SHIFT    = 36;
    localparam int AXIS_LHS_K   = 100;
    localparam int AXIS_RHS_K   = 81;
    localparam int SHIFT_W      = 7;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_LD,
        S_NORM,
        S_MUL_LD,
        S_MUL,
        S_MUL_WB,
        S_AXIS,
        S_SQRT_LD,
        S_SQRT,
        S_DIV_LD,
        S_DIV,
        S_ACC,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_SQ,
        OP_CROSS,
        OP_DOT,
        OP_TERM
    } t_op;

    typedef enum logic [1:0] {
        PH_D,
        PH_C,
        PH_E
    } t_phase;

    function automatic logic [1:0] term_row(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd5, 4'd6:       r = 2'd1;
            4'd7, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] term_col(input logic [3:0] k);
        logic [1:0] c;
        unique case (k)
            4'd0:                   c = 2'd0;
            4'd1, 4'd4:             c = 2'd1;
            4'd2, 4'd5, 4'd7:       c = 2'd2;
            default:                c = 2'd3;
        endcase
        return c;
    endfunction

    function automatic logic [SHIFT_W-1:0] frac_of(input logic [1:0] a);
        return (a == 2'd3) ? SHIFT_W'(UNIT_FRAC + COORD_FRAC_BITS) : SHIFT_W'(UNIT_FRAC);
    endfunction

    function automatic logic [SHIFT_W-1:0] term_shift(input logic [3:0] k);
        return frac_of(term_row(k)) + frac_of(term_col(k)) - SHIFT_W'(ACC_FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/edge_line_quadric_accumulator_top.sv @@
// edge line quadric accumulator: a sequencer around a shared 32x32 multiplier, a bit-serial
// square root and a restoring divider; uses elqa_pkg
// work per edge: a zero-length edge goes straight to the finish state; a normal edge runs 41
//   products, 20 accumulations, two 32-step roots, six divisions and rescales
// one edge at a time: a new edge is taken only in idle; a result beat waits in an output register
// reset: synchronous active-low i_rst_n clears the sequencer, sums, flag and output valid
`default_nettype none

module edge_line_quadric_accumulator_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output      logic                                   o_ready,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_vertex_x,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_vertex_y,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_vertex_z,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_neighbor_x,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_neighbor_y,
    input  wire logic signed [elqa_pkg::COORD_WIDTH-1:0] i_neighbor_z,
    input  wire logic                                   i_last_edge,
    output      logic                                   o_valid,
    input  wire logic                                   i_ready,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_xx,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_xy,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_xz,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_xw,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_yy,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_yz,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_yw,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_zz,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_zw,
    output      logic signed [elqa_pkg::ACC_W-1:0]       o_q_ww,
    output      logic                                   o_degenerate_seen
);
    import elqa_pkg::*;

    // sequencer
    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_phase r_phase, n_phase;
    logic [3:0] r_idx, n_idx;
    logic [4:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       r_flag, n_flag;

    // vertex and working vectors
    logic signed [COORD_WIDTH-1:0] r_p   [3], n_p   [3];
    logic signed [CROSS_W-1:0]     r_vec [3], n_vec [3];
    logic        [CROSS_W-1:0]     r_mag [3], n_mag [3];
    logic                          r_sgn [3], n_sgn [3];
    logic        [CROSS_W-1:0]     r_top, n_top;
    logic signed [DIFF_W-1:0]      r_ds  [3], n_ds  [3];
    logic signed [DIFF_W-1:0]      r_c   [3], n_c   [3];
    logic signed [CROSS_W-1:0]     r_e   [3], n_e   [3];
    logic        [SQ_W-1:0]        r_sq  [3], n_sq  [3];
    logic signed [CROSS_W-1:0]     r_tmp, n_tmp;

    // shared multiplier
    logic [ACC_W-1:0]  r_ma, n_ma, r_mb, n_mb;
    logic              r_msgn, n_msgn;
    logic [ACC_W-1:0]  r_pp, n_pp;
    logic [1:0]        r_pp_pos, n_pp_pos;
    logic [PROD_W-1:0] r_prod, n_prod;

    // root and divider
    logic [ACC_W-1:0]  r_rv, n_rv, r_res, n_res, r_bit, n_bit;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_quo, n_quo;

    // plane and sums
    logic signed [UNIT_W-1:0] r_n [3], n_n [3];
    logic signed [DOT_W-1:0]  r_dot, n_dot, r_w, n_w;
    t_acc r_q  [NUM_TERMS], n_q  [NUM_TERMS];
    t_acc r_oq [NUM_TERMS], n_oq [NUM_TERMS];
    logic r_odeg, n_odeg, r_ovalid, n_ovalid;

    // operand select for the multiplier
    t_acc op_a, op_b;
    t_acc pl [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pl[i] = ACC_W'(r_n[i]);
        end
        pl[3] = ACC_W'(r_w);
        op_a = '0;
        op_b = '0;
        unique case (r_op)
            OP_SQ: begin
                op_a = ACC_W'(r_mag[r_idx[1:0]]);
                op_b = ACC_W'(r_mag[r_idx[1:0]]);
            end
            OP_CROSS: begin
                // e = ds x c, two products per component
                priority case (r_idx)
                    4'd0:    begin op_a = ACC_W'(r_ds[1]); op_b = ACC_W'(r_c[2]); end
                    4'd1:    begin op_a = ACC_W'(r_ds[2]); op_b = ACC_W'(r_c[1]); end
                    4'd2:    begin op_a = ACC_W'(r_ds[2]); op_b = ACC_W'(r_c[0]); end
                    4'd3:    begin op_a = ACC_W'(r_ds[0]); op_b = ACC_W'(r_c[2]); end
                    4'd4:    begin op_a = ACC_W'(r_ds[0]); op_b = ACC_W'(r_c[1]); end
                    default: begin op_a = ACC_W'(r_ds[1]); op_b = ACC_W'(r_c[0]); end
                endcase
            end
            OP_DOT: begin
                op_a = ACC_W'(r_n[r_idx[1:0]]);
                op_b = ACC_W'(r_p[r_idx[1:0]]);
            end
            default: begin
                op_a = pl[term_row(r_idx)];
                op_b = pl[term_col(r_idx)];
            end
        endcase
    end

    // helpers for the sequencer
    logic signed [ACC_W-1:0]  prod_s;
    logic [SUM_W-1:0]         sum_sq;
    logic [AXIS_W-1:0]        axis_lhs, axis_rhs;
    logic [ACC_W-1:0]         sq_t;
    logic [REM_W:0]           rem2;
    logic [SHIFT_W-1:0]       t_shift;
    logic [ACC_W-1:0]         sat_lim, sat_val;
    t_acc                     term_v;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [DIFF_W-1:0] sv [3];
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [DIFF_W-1:0] d [3];

    assign prod_s   = r_msgn ? -t_acc'(r_prod[ACC_W-1:0]) : t_acc'(r_prod[ACC_W-1:0]);
    assign sum_sq   = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign axis_lhs = AXIS_W'(r_sq[0]) * AXIS_W'(AXIS_LHS_K);
    assign axis_rhs = AXIS_W'(sum_sq) * AXIS_W'(AXIS_RHS_K);
    assign sq_t     = r_res + r_bit;
    assign rem2     = {r_rem, 1'b0};
    assign t_shift  = term_shift(r_idx);
    assign sat_lim  = r_msgn ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    assign sat_val  = (r_prod[PROD_W-1:ACC_W] != '0 || r_prod[ACC_W-1:0] > sat_lim)
                      ? sat_lim : r_prod[ACC_W-1:0];
    assign term_v   = r_msgn ? -t_acc'(sat_val) : t_acc'(sat_val);
    assign acc_sum  = (ACC_W+1)'(r_q[r_idx]) + (ACC_W+1)'(term_v);
    assign dot_next = r_dot + DOT_W'(prod_s);

    always_comb begin
        d[0] = DIFF_W'(i_neighbor_x) - DIFF_W'(i_vertex_x);
        d[1] = DIFF_W'(i_neighbor_y) - DIFF_W'(i_vertex_y);
        d[2] = DIFF_W'(i_neighbor_z) - DIFF_W'(i_vertex_z);
        for (int i = 0; i < 3; i++) begin
            sv[i] = r_sgn[i] ? -DIFF_W'(r_mag[i]) : DIFF_W'(r_mag[i]);
        end
    end

    // next state and datapath
    always_comb begin
        logic [CROSS_W-1:0] m;
        logic [ROOT_W-1:0]  q;
        n_state = r_state;  n_op = r_op;   n_phase = r_phase;
        n_idx = r_idx;      n_cnt = r_cnt; n_last = r_last;  n_flag = r_flag;
        n_p = r_p;   n_vec = r_vec; n_mag = r_mag; n_sgn = r_sgn; n_top = r_top;
        n_ds = r_ds; n_c = r_c;     n_e = r_e;     n_sq = r_sq;   n_tmp = r_tmp;
        n_ma = r_ma; n_mb = r_mb;   n_msgn = r_msgn; n_pp = r_pp; n_pp_pos = r_pp_pos;
        n_prod = r_prod;
        n_rv = r_rv; n_res = r_res; n_bit = r_bit; n_root = r_root;
        n_rem = r_rem; n_quo = r_quo;
        n_n = r_n;   n_dot = r_dot; n_w = r_w;
        n_q = r_q;   n_oq = r_oq;   n_odeg = r_odeg;
        n_ovalid = r_ovalid & ~i_ready;
        m = '0;
        q = '0;
        o_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_p[0] = i_vertex_x;
                    n_p[1] = i_vertex_y;
                    n_p[2] = i_vertex_z;
                    n_last = i_last_edge;
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i] = CROSS_W'(d[i]);
                    end
                    n_phase = PH_D;
                    if (d[0] == '0 && d[1] == '0 && d[2] == '0) begin
                        n_flag  = 1'b1;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_NORM_LD;
                    end
                end
            end

            S_NORM_LD: begin
                n_top = '0;
                for (int i = 0; i < 3; i++) begin
                    m = (r_vec[i] < 0) ? CROSS_W'(-r_vec[i]) : CROSS_W'(r_vec[i]);
                    n_mag[i] = m;
                    n_sgn[i] = r_vec[i] < 0;
                    if (m > n_top) begin
                        n_top = m;
                    end
                end
                n_state = S_NORM;
            end

            S_NORM: begin
                // power-of-two rescale, up to four bits a cycle
                priority if (r_top >= CROSS_W'(1) << (SCALE_HI + 3)) begin
                    n_top = r_top >> 4;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 4;
                end else if (r_top >= CROSS_W'(1) << SCALE_HI) begin
                    n_top = r_top >> 1;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 1;
                end else if (r_top != '0 && r_top < CROSS_W'(1) << (SCALE_HI - 5)) begin
                    n_top = r_top << 4;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 4;
                end else if (r_top != '0 && r_top < CROSS_W'(1) << (SCALE_HI - 1)) begin
                    n_top = r_top << 1;
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 1;
                end else begin
                    if (r_phase == PH_D) begin
                        n_ds = sv;
                    end
                    n_op    = OP_SQ;
                    n_idx   = '0;
                    n_state = S_MUL_LD;
                end
            end

            S_MUL_LD: begin
                n_ma    = (op_a < 0) ? ACC_W'(-op_a) : ACC_W'(op_a);
                n_mb    = (op_b < 0) ? ACC_W'(-op_b) : ACC_W'(op_b);
                n_msgn  = (op_a < 0) != (op_b < 0);
                n_prod  = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end

            S_MUL: begin
                // four 32x32 partial products, each registered and added in the next cycle
                if (r_cnt < 5'd4) begin
                    n_pp = ACC_W'((r_cnt[1] ? r_ma[ACC_W-1:HALF_W] : r_ma[HALF_W-1:0]) *
                                  (r_cnt[0] ? r_mb[ACC_W-1:HALF_W] : r_mb[HALF_W-1:0]));
                    n_pp_pos = 2'(r_cnt[1]) + 2'(r_cnt[0]);
                end
                if (r_cnt != '0) begin
                    n_prod = r_prod + (PROD_W'(r_pp) << {r_pp_pos, 5'b0});
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    n_state = S_MUL_WB;
                end
            end

            S_MUL_WB: begin
                unique case (r_op)
                    OP_SQ: begin
                        n_sq[r_idx[1:0]] = r_prod[SQ_W-1:0];
                        if (r_idx == 4'd2) begin
                            n_state = (r_phase == PH_D) ? S_AXIS : S_SQRT_LD;
                        end else begin
                            n_idx   = r_idx + 4'd1;
                            n_state = S_MUL_LD;
                        end
                    end
                    OP_CROSS: begin
                        if (!r_idx[0]) begin
                            n_tmp = CROSS_W'(prod_s);
                        end else begin
                            n_e[r_idx[2:1]] = r_tmp - CROSS_W'(prod_s);
                        end
                        if (r_idx == 4'd5) begin
                            for (int i = 0; i < 3; i++) n_vec[i] = CROSS_W'(r_c[i]);
                            n_phase = PH_C;
                            n_state = S_NORM_LD;
                        end else begin
                            n_idx   = r_idx + 4'd1;
                            n_state = S_MUL_LD;
                        end
                    end
                    OP_DOT: begin
                        n_dot = (r_idx == '0) ? DOT_W'(prod_s) : dot_next;
                        if (r_idx == 4'd2) begin
                            n_w     = -dot_next;
                            n_op    = OP_TERM;
                            n_idx   = '0;
                        end else begin
                            n_idx   = r_idx + 4'd1;
                        end
                        n_state = S_MUL_LD;
                    end
                    default: begin
                        // round half away from zero on the magnitude
                        n_prod  = (r_prod + (PROD_W'(1) << (t_shift - SHIFT_W'(1)))) >> t_shift;
                        n_state = S_ACC;
                    end
                endcase
            end

            S_AXIS: begin
                if (axis_lhs < axis_rhs) begin
                    n_c[0] = '0;     n_c[1] = r_ds[2]; n_c[2] = -r_ds[1];
                end else begin
                    n_c[0] = -r_ds[2]; n_c[1] = '0;   n_c[2] = r_ds[0];
                end
                n_op    = OP_CROSS;
                n_idx   = '0;
                n_state = S_MUL_LD;
            end

            S_SQRT_LD: begin
                n_rv    = ACC_W'(sum_sq) << SQRT_PRE;
                n_res   = '0;
                n_bit   = ACC_W'(1) << (ACC_W - 2);
                n_state = S_SQRT;
            end

            S_SQRT: begin
                if (r_rv >= sq_t) begin
                    n_rv  = r_rv - sq_t;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_root  = (n_res == '0) ? ROOT_W'(1) : ROOT_W'(n_res);
                    n_idx   = '0;
                    n_state = S_DIV_LD;
                end
            end

            S_DIV_LD: begin
                n_rem   = REM_W'(r_mag[r_idx[1:0]][SCALE_HI-1:0]) << (DIV_SHIFT - ROOT_W);
                n_quo   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end

            S_DIV: begin
                if (rem2 >= (REM_W+1)'(r_root)) begin
                    n_rem = REM_W'(rem2 - (REM_W+1)'(r_root));
                    n_quo = {r_quo[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem = REM_W'(rem2);
                    n_quo = {r_quo[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    q = (n_quo > ROOT_W'(1 << UNIT_FRAC)) ? ROOT_W'(1 << UNIT_FRAC) : n_quo;
                    n_n[r_idx[1:0]] = r_sgn[r_idx[1:0]] ? -UNIT_W'(q) : UNIT_W'(q);
                    if (r_idx == 4'd2) begin
                        n_op    = OP_DOT;
                        n_idx   = '0;
                        n_state = S_MUL_LD;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = S_DIV_LD;
                    end
                end
            end

            S_ACC: begin
                // saturating add into the running sum
                priority if (acc_sum > $signed({2'b00, {(ACC_W-1){1'b1}}})) begin
                    n_q[r_idx] = {1'b0, {(ACC_W-1){1'b1}}};
                end else if (acc_sum < $signed({2'b11, {(ACC_W-1){1'b0}}})) begin
                    n_q[r_idx] = {1'b1, {(ACC_W-1){1'b0}}};
                end else begin
                    n_q[r_idx] = acc_sum[ACC_W-1:0];
                end
                if (r_idx == 4'(NUM_TERMS - 1)) begin
                    if (r_phase == PH_C) begin
                        n_vec   = r_e;
                        n_phase = PH_E;
                        n_state = S_NORM_LD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = S_MUL_LD;
                end
            end

            S_FINISH: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_ovalid || i_ready) begin
                    n_oq     = r_q;
                    n_odeg   = r_flag;
                    n_ovalid = 1'b1;
                    for (int k = 0; k < NUM_TERMS; k++) n_q[k] = '0;
                    n_flag   = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_SQ;
            r_phase  <= PH_D;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_TERMS; k++) r_q[k] <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
            r_q      <= n_q;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p <= n_p;   r_vec <= n_vec; r_mag <= n_mag; r_sgn <= n_sgn; r_top <= n_top;
        r_ds <= n_ds; r_c <= n_c;     r_e <= n_e;     r_sq <= n_sq;   r_tmp <= n_tmp;
        r_ma <= n_ma; r_mb <= n_mb;   r_msgn <= n_msgn; r_pp <= n_pp; r_pp_pos <= n_pp_pos;
        r_prod <= n_prod;
        r_rv <= n_rv; r_res <= n_res; r_bit <= n_bit; r_root <= n_root;
        r_rem <= n_rem; r_quo <= n_quo;
        r_n <= n_n;   r_dot <= n_dot; r_w <= n_w;
        r_oq <= n_oq; r_odeg <= n_odeg;
    end

    assign o_valid           = r_ovalid;
    assign o_q_xx            = r_oq[0];
    assign o_q_xy            = r_oq[1];
    assign o_q_xz            = r_oq[2];
    assign o_q_xw            = r_oq[3];
    assign o_q_yy            = r_oq[4];
    assign o_q_yz            = r_oq[5];
    assign o_q_yw            = r_oq[6];
    assign o_q_zz            = r_oq[7];
    assign o_q_zw            = r_oq[8];
    assign o_q_ww            = r_oq[9];
    assign o_degenerate_seen = r_odeg;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// self-checking bench for edge_line_quadric_accumulator_top: directed edge table, then
// random vertex fans checked against a fixed-point quadric predictor; uses elqa_pkg
`timescale 1ns / 1ps

module testbench;
    import elqa_pkg::*;

    localparam int N_RANDOM    = 1530;
    localparam int CALM_AFTER  = 1350;   // no idling on either side past this beat count
    localparam int LONG_HOLD   = 6000;   // receiver hold-off, enough to back up the input
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_AT    = 800;
    localparam int TAIL_CYCLES = 700;    // about one normal edge of latency

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef longint t_vec3 [3];

    typedef struct {
        t_coord vx, vy, vz, nx, ny, nz;
        bit     last;
        bit     typed;     // expected result is written in the row
        bit     t_degen;   // typed rows always expect zero sums
    } t_edge_row;

    typedef struct {
        t_acc q [NUM_TERMS];
        bit   degen;
    } t_quadric;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_vertex_x, i_vertex_y, i_vertex_z;
    t_coord i_neighbor_x, i_neighbor_y, i_neighbor_z;
    logic   i_last_edge;
    logic   o_valid;
    logic   i_ready;
    t_acc   o_q_xx, o_q_xy, o_q_xz, o_q_xw, o_q_yy;
    t_acc   o_q_yz, o_q_yw, o_q_zz, o_q_zw, o_q_ww;
    logic   o_degenerate_seen;

    edge_line_quadric_accumulator_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_vertex_x        (i_vertex_x),
        .i_vertex_y        (i_vertex_y),
        .i_vertex_z        (i_vertex_z),
        .i_neighbor_x      (i_neighbor_x),
        .i_neighbor_y      (i_neighbor_y),
        .i_neighbor_z      (i_neighbor_z),
        .i_last_edge       (i_last_edge),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_q_xx            (o_q_xx),
        .o_q_xy            (o_q_xy),
        .o_q_xz            (o_q_xz),
        .o_q_xw            (o_q_xw),
        .o_q_yy            (o_q_yy),
        .o_q_yz            (o_q_yz),
        .o_q_yw            (o_q_yw),
        .o_q_zz            (o_q_zz),
        .o_q_zw            (o_q_zw),
        .o_q_ww            (o_q_ww),
        .o_degenerate_seen (o_degenerate_seen)
    );

    // row/column of each of the ten distinct symmetric entries, w last
    localparam int ENTRY_ROW [NUM_TERMS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int ENTRY_COL [NUM_TERMS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
    string entry_name [NUM_TERMS] = '{"q_xx", "q_xy", "q_xz", "q_xw", "q_yy",
                                      "q_yz", "q_yw", "q_zz", "q_zw", "q_ww"};

    // predictor state, mirrors the block's accumulators
    t_acc quadric_acc [NUM_TERMS];
    bit   degen_pending;

    t_quadric pending_quadrics [$];

    int  n_errors    = 0;
    int  n_edges     = 0;
    int  n_results   = 0;
    int  n_zero_len  = 0;
    int  n_y_axis    = 0;
    bit  calm        = 1'b0;
    bit  hold_req    = 1'b0;

    // ---------------------------------------------------------------- clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(0) - x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b   = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   -= res + b;
                res  = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // power-of-two rescale so the biggest magnitude lands in [2^23, 2^24)
    function automatic t_vec3 scale_top24(t_vec3 w);
        t_vec3           o;
        longint unsigned m [3];
        longint unsigned top = 0;
        longint unsigned v;
        int              rs = 0;
        int              ls = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(w[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return '{0, 0, 0};
        while ((top >> rs) >= (64'd1 << 24)) rs++;
        if (rs == 0)
            while ((top << ls) < (64'd1 << 23)) ls++;
        for (int i = 0; i < 3; i++) begin
            v    = (m[i] >> rs) << ls;
            o[i] = (w[i] < 0) ? -longint'(v) : longint'(v);
        end
        return o;
    endfunction

    // unit vector with UNIT_FRAC fraction bits
    function automatic t_vec3 unit_of(t_vec3 w);
        t_vec3           v;
        t_vec3           n;
        longint unsigned sum = 0;
        longint unsigned r;
        longint unsigned q;
        v = scale_top24(w);
        for (int i = 0; i < 3; i++) sum += mag(v[i]) * mag(v[i]);
        r = int_sqrt(sum << SQRT_PRE);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = (mag(v[i]) << DIV_SHIFT) / r;
            if (q > (64'd1 << UNIT_FRAC)) q = 64'd1 << UNIT_FRAC;
            n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return n;
    endfunction

    // exact product, shifted with round half away from zero, saturated
    function automatic t_acc term_of(longint x, longint y, int sh);
        logic [127:0] m;
        logic [127:0] limit;
        bit           neg;
        neg   = (x < 0) != (y < 0);
        m     = 128'(mag(x)) * 128'(mag(y));
        m     = (m + (128'd1 << (sh - 1))) >> sh;
        limit = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (m > limit) m = limit;
        return neg ? -t_acc'(m[63:0]) : t_acc'(m[63:0]);
    endfunction

    function automatic t_acc sat_sum(t_acc a, t_acc b);
        logic signed [ACC_W:0] t;
        t = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (t > $signed({2'b00, {(ACC_W-1){1'b1}}})) return {1'b0, {(ACC_W-1){1'b1}}};
        if (t < $signed({2'b11, {(ACC_W-1){1'b0}}})) return {1'b1, {(ACC_W-1){1'b0}}};
        return t[ACC_W-1:0];
    endfunction

    function automatic int frac_bits(int idx);
        return (idx == 3) ? UNIT_FRAC + COORD_FRAC_BITS : UNIT_FRAC;
    endfunction

    task automatic add_plane(input t_vec3 n, input t_vec3 p);
        longint pl [4];
        int     a, b;
        pl[0] = n[0];
        pl[1] = n[1];
        pl[2] = n[2];
        pl[3] = -(n[0] * p[0] + n[1] * p[1] + n[2] * p[2]);
        for (int k = 0; k < NUM_TERMS; k++) begin
            a = ENTRY_ROW[k];
            b = ENTRY_COL[k];
            quadric_acc[k] = sat_sum(quadric_acc[k],
                term_of(pl[a], pl[b], frac_bits(a) + frac_bits(b) - ACC_FRAC_BITS));
        end
    endtask

    task automatic predict_edge(input t_edge_row r, output bit emit, output t_quadric res);
        t_vec3           p, d, ds, c, e;
        longint unsigned len2, dx2;
        p = '{longint'(r.vx), longint'(r.vy), longint'(r.vz)};
        d = '{longint'(r.nx) - p[0], longint'(r.ny) - p[1], longint'(r.nz) - p[2]};
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            degen_pending = 1'b1;
            n_zero_len++;
        end else begin
            ds   = scale_top24(d);
            dx2  = mag(ds[0]) * mag(ds[0]);
            len2 = dx2 + mag(ds[1]) * mag(ds[1]) + mag(ds[2]) * mag(ds[2]);
            // cross with x axis unless the edge runs mostly along x
            if (AXIS_LHS_K * dx2 < AXIS_RHS_K * len2) begin
                c = '{0, ds[2], -ds[1]};
            end else begin
                c = '{-ds[2], 0, ds[0]};
                n_y_axis++;
            end
            e[0] = ds[1] * c[2] - ds[2] * c[1];
            e[1] = ds[2] * c[0] - ds[0] * c[2];
            e[2] = ds[0] * c[1] - ds[1] * c[0];
            add_plane(unit_of(c), p);
            add_plane(unit_of(e), p);
        end
        emit = r.last;
        res.q = quadric_acc;
        res.degen = degen_pending;
        if (r.last) begin
            foreach (quadric_acc[k]) quadric_acc[k] = '0;
            degen_pending = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input t_acc got, input t_acc want);
        n_errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_acc     got [NUM_TERMS];
        t_quadric want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_q_xx, o_q_xy, o_q_xz, o_q_xw, o_q_yy,
                    o_q_yz, o_q_yw, o_q_zz, o_q_zw, o_q_ww};
            if (pending_quadrics.size() == 0) begin
                report_mismatch("unexpected result beat", 0, 0);
            end else begin
                want = pending_quadrics.pop_front();
                n_results++;
                for (int k = 0; k < NUM_TERMS; k++)
                    if (got[k] !== want.q[k]) report_mismatch(entry_name[k], got[k], want.q[k]);
                if (o_degenerate_seen !== want.degen)
                    report_mismatch("degenerate_seen", o_degenerate_seen, want.degen);
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    initial begin
        i_ready <= 1'b0;
        forever begin
            if (hold_req) begin
                // long hold-off: block fills, o_ready must drop
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------- sender
    task automatic send_edge(input t_edge_row r);
        bit       emit;
        t_quadric res;
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_vertex_x   <= r.vx;
        i_vertex_y   <= r.vy;
        i_vertex_z   <= r.vz;
        i_neighbor_x <= r.nx;
        i_neighbor_y <= r.ny;
        i_neighbor_z <= r.nz;
        i_last_edge  <= r.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_edges++;
        predict_edge(r, emit, res);
        if (r.typed) begin
            foreach (res.q[k]) res.q[k] = '0;
            res.degen = r.t_degen;
        end
        if (emit) pending_quadrics.insert(pending_quadrics.size(), res);
    endtask

    // signed offset of a given bit width added to a coordinate, wraps at the field
    function automatic t_coord nudge(t_coord v, int bits);
        longint span;
        span = longint'(1) << bits;
        return t_coord'(longint'(v) + longint'($urandom_range(span - 1, 0)) - span / 2);
    endfunction

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = -24'sh800000;
    localparam t_coord ONE  = 24'sh010000;

    // directed rows: zero sums only where the answer is obvious
    t_edge_row directed_edges [] = '{
        // zero-length last edge straight out of reset: zero sums, flag set
        '{0, 0, 0, 0, 0, 0, 1, 1, 1},
        // unit edges along each axis, x picks the y-axis cross
        '{0, 0, 0, ONE, 0, 0, 1, 0, 0},
        '{0, 0, 0, 0, ONE, 0, 1, 0, 0},
        '{0, 0, 0, 0, 0, ONE, 1, 0, 0},
        // coordinate extremes both ways
        '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, 0, 0},
        '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0, 0},
        '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1, 0, 0},
        // zero-length edge mid-fan, flag must ride along to the next result
        '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0},
        '{CMAX, CMAX, CMAX, 0, 0, 0, 1, 0, 0},
        // one-lsb edges
        '{0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, -1, -1, -1, 1, 0, 0},
        // either side of the 0.9 axis threshold
        '{0, 0, 0, 90, 43, 0, 0, 0, 0},
        '{0, 0, 0, 90, 44, 0, 1, 0, 0},
        '{0, 0, 0, -90, 0, 43, 0, 0, 0},
        '{0, 0, 0, -90, 0, 44, 1, 0, 0},
        // big plane offsets piling up on w
        '{CMAX, CMIN, CMAX, CMAX, CMIN, 0, 0, 0, 0},
        '{CMAX, CMIN, CMAX, 0, CMIN, CMAX, 0, 0, 0},
        '{CMAX, CMIN, CMAX, CMAX, 0, CMAX, 1, 0, 0},
        // zero-length last edges after a clear
        '{5, 6, 7, 5, 6, 7, 1, 1, 1},
        '{CMIN, 0, CMAX, CMIN, 0, CMAX, 0, 0, 0},
        '{1, 2, 3, 1, 2, 3, 1, 1, 1}
    };

    initial begin
        t_edge_row r;
        int        fan;
        int        kind;
        int        sent;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_vertex_x   <= '0;
        i_vertex_y   <= '0;
        i_vertex_z   <= '0;
        i_neighbor_x <= '0;
        i_neighbor_y <= '0;
        i_neighbor_z <= '0;
        i_last_edge  <= 1'b0;
        foreach (quadric_acc[k]) quadric_acc[k] = '0;
        degen_pending = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_edges[i]) send_edge(directed_edges[i]);

        // random vertex fans: a vertex with 1..6 edges, last flag on the final one unless flipped to break the fan
        sent = 0;
        while (sent < N_RANDOM) begin
            fan     = $urandom_range(6, 1);
            r.typed = 1'b0;
            if ($urandom_range(3) == 0) begin
                r.vx = nudge(0, 12);
                r.vy = nudge(0, 12);
                r.vz = nudge(0, 12);
            end else begin
                r.vx = any_coord();
                r.vy = any_coord();
                r.vz = any_coord();
            end
            for (int j = 0; j < fan && sent < N_RANDOM; j++) begin
                kind = $urandom_range(99);
                if (kind < 20) begin
                    r.nx = any_coord();
                    r.ny = any_coord();
                    r.nz = any_coord();
                end else if (kind < 55) begin
                    r.nx = nudge(r.vx, 18);
                    r.ny = nudge(r.vy, 18);
                    r.nz = nudge(r.vz, 18);
                end else if (kind < 72) begin
                    // mostly along x, exercises the y-axis cross
                    r.nx = nudge(r.vx, 20);
                    r.ny = nudge(r.vy, $urandom_range(12, 1));
                    r.nz = nudge(r.vz, $urandom_range(12, 1));
                end else if (kind < 80) begin
                    r.nx = r.vx;
                    r.ny = r.vy;
                    r.nz = r.vz;
                end else if (kind < 92) begin
                    r.nx = nudge(r.vx, 2);
                    r.ny = nudge(r.vy, 2);
                    r.nz = nudge(r.vz, 2);
                end else begin
                    r.nx = nudge(r.vx, $urandom_range(24, 1));
                    r.ny = nudge(r.vy, $urandom_range(24, 1));
                    r.nz = nudge(r.vz, $urandom_range(24, 1));
                end
                r.last = (j == fan - 1);
                if ($urandom_range(19) == 0) r.last = ~r.last;   // broken fans
                r.t_degen = 1'b0;
                if (sent == HOLD_AT) hold_req = 1'b1;
                if (sent == DRAIN_AT) begin
                    // sender pause until every result has drained
                    i_valid <= 1'b0;
                    while (pending_quadrics.size() != 0) @(posedge i_clk);
                end
                if (sent == CALM_AFTER) calm = 1'b1;
                send_edge(r);
                sent++;
            end
        end
        // close any open fan so its sums come out
        r.vx = 0; r.vy = 0; r.vz = 0;
        r.nx = ONE; r.ny = ONE; r.nz = 0;
        r.last = 1'b1;
        send_edge(r);
        i_valid <= 1'b0;

        while (pending_quadrics.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d edges, %0d quadric results, %0d zero-length, %0d y-axis crosses",
                 n_edges, n_results, n_zero_len, n_y_axis);
        $display("directed extremes, threshold edges, long output hold-off and a full drain");
        if (n_errors == 0 && pending_quadrics.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #30ms;
        $display("timeout with %0d results outstanding", pending_quadrics.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ edge_line_quadric_accumulator_top.f @@
hw/rtl/elqa_pkg.sv
hw/rtl/edge_line_quadric_accumulator_top.sv
test/testbench.sv
